FILE: hdl/bde_pkg.sv
package bde_pkg;

  // Dictionary geometry
  localparam int NUM_CODES     = 256;
  localparam int MAX_ENTRY_LEN = 255;
  localparam int OUT_LANES     = 4;

  localparam int BYTE_W  = 8;
  localparam int CODE_W  = $clog2(NUM_CODES);
  localparam int LEN_W   = 8;
  localparam int SLOT_W  = 8;                      // 256 byte slots per entry
  localparam int LANE_W  = $clog2(OUT_LANES);
  localparam int WORD_W  = SLOT_W - LANE_W;        // word index within a slot
  localparam int BANK_AW = CODE_W + WORD_W;
  localparam int CNT_W   = $clog2(OUT_LANES + 1);
  localparam int OUT_W   = OUT_LANES * BYTE_W;
  localparam int TOTAL_W = 32;

  typedef enum logic [1:0] {
    ACT_SET_LEN    = 2'd0,
    ACT_WRITE_BYTE = 2'd1,
    ACT_DECODE     = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_RUN
  } seq_state_e;

  // Word read into the banked byte store
  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
  } mem_rd_t;

  // Side info that travels with a word read
  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } emit_t;

endpackage

FILE: hdl/bde_len_table.sv
module bde_len_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [bde_pkg::CODE_W-1:0]      wr_addr_i,
  input  logic [bde_pkg::LEN_W-1:0]       wr_data_i,
  input  logic                            rd_en_i,
  input  logic [bde_pkg::CODE_W-1:0]      rd_addr_i,
  output logic [bde_pkg::LEN_W-1:0]       len_o
);

  logic [bde_pkg::LEN_W-1:0]     mem_q [bde_pkg::NUM_CODES];
  logic [bde_pkg::NUM_CODES-1:0] valid_q;
  logic [bde_pkg::LEN_W-1:0]     rd_data_q;
  logic                          rd_vld_q;

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign len_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: hdl/bde_byte_mem.sv
module bde_byte_mem (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [bde_pkg::CODE_W-1:0]    wr_code_i,
  input  logic [bde_pkg::SLOT_W-1:0]    wr_pos_i,
  input  logic [bde_pkg::BYTE_W-1:0]    wr_data_i,
  input  bde_pkg::mem_rd_t              rd_i,
  output logic [bde_pkg::OUT_W-1:0]     rd_data_o
);

  // one bank per output lane, a byte goes to the bank of its low position bits
  logic [bde_pkg::BANK_AW-1:0] wr_addr;

  assign wr_addr = {wr_code_i, wr_pos_i[bde_pkg::SLOT_W-1:bde_pkg::LANE_W]};

  for (genvar l = 0; l < bde_pkg::OUT_LANES; l++) begin : g_bank
    logic [bde_pkg::BYTE_W-1:0] mem_q [2**bde_pkg::BANK_AW];
    logic [bde_pkg::BYTE_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_pos_i[bde_pkg::LANE_W-1:0] == bde_pkg::LANE_W'(l))) begin
        mem_q[wr_addr] <= wr_data_i;
      end
      if (rd_i.en) begin
        rd_q <= mem_q[rd_i.addr];
      end
    end

    assign rd_data_o[l*bde_pkg::BYTE_W +: bde_pkg::BYTE_W] = rd_q;
  end

endmodule

FILE: hdl/bde_seq.sv
module bde_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bde_pkg::CODE_W-1:0]     code_i,
  input  logic [bde_pkg::LEN_W-1:0]      len_i,
  output logic                           busy_o,
  output bde_pkg::mem_rd_t               rd_o,
  output bde_pkg::emit_t                 emit_o,
  output logic [bde_pkg::TOTAL_W-1:0]    total_o
);

  bde_pkg::seq_state_e          state_q, state_d;
  logic [bde_pkg::CODE_W-1:0]   code_q;
  logic [bde_pkg::LEN_W-1:0]    done_q, done_d;
  bde_pkg::emit_t               emit_q, emit_d;
  logic [bde_pkg::TOTAL_W-1:0]  total_q, total_d;

  logic [bde_pkg::LEN_W-1:0]    remain;
  logic                         last_word;
  logic [bde_pkg::CNT_W-1:0]    cnt;
  logic [bde_pkg::TOTAL_W:0]    sum;
  logic                         issue;

  // shared step unit: bytes left, word size, saturating total
  assign remain    = len_i - done_q;
  assign last_word = remain <= bde_pkg::LEN_W'(bde_pkg::OUT_LANES);
  assign cnt       = last_word ? remain[bde_pkg::CNT_W-1:0]
                               : bde_pkg::CNT_W'(bde_pkg::OUT_LANES);
  assign sum       = {1'b0, total_q} + (bde_pkg::TOTAL_W+1)'(cnt);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bde_pkg::ST_IDLE: begin
        if (start_i) state_d = bde_pkg::ST_LEN;
      end
      bde_pkg::ST_LEN: begin
        if (len_i == '0) state_d = bde_pkg::ST_IDLE;
        else             state_d = bde_pkg::ST_RUN;
      end
      bde_pkg::ST_RUN: begin
        if (last_word) state_d = bde_pkg::ST_IDLE;
      end
      default: state_d = bde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    issue   = 1'b0;
    busy_o  = 1'b1;
    case (state_q)
      bde_pkg::ST_IDLE: busy_o = 1'b0;
      bde_pkg::ST_LEN:  busy_o = 1'b1;
      bde_pkg::ST_RUN:  issue  = 1'b1;
      default:          busy_o = 1'b1;
    endcase
    rd_o.en   = issue;
    rd_o.addr = {code_q, done_q[bde_pkg::SLOT_W-1:bde_pkg::LANE_W]};

    emit_d.vld  = issue;
    emit_d.cnt  = cnt;
    emit_d.last = last_word;

    done_d  = done_q;
    total_d = total_q;
    if (state_q == bde_pkg::ST_IDLE) begin
      done_d = '0;
    end else if (issue) begin
      done_d  = done_q + bde_pkg::LEN_W'(bde_pkg::OUT_LANES);
      total_d = sum[bde_pkg::TOTAL_W] ? '1 : sum[bde_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bde_pkg::ST_IDLE;
      done_q  <= '0;
      emit_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      emit_q  <= emit_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == bde_pkg::ST_IDLE)) begin
      code_q <= code_i;
    end
  end

  assign emit_o  = emit_q;
  assign total_o = total_q;

endmodule

FILE: hdl/byte_dictionary_expander_unit.sv
// Dictionary byte-code expander.
//
// Command channel: an item (action_i, entry_i, position_i, value_i) is taken
// on a rising edge with start high and busy low.
//   set length  : stores value_i as entry_i's length, no output.
//   write byte  : stores value_i at position_i of entry_i, no output.
//   decode      : emits entry_i's bytes, four per word, low lane first.
// A decode first reads the length table, then reads one word per cycle from
// all four byte banks at once; each word shows up on the result ports in the
// cycle after its read, for exactly one cycle, with strobe_o high. The
// single-port word read of the banked byte store sets the one-word-per-cycle
// pace.
// total_length_o is a saturating count of all bytes expanded since reset,
// including the word on the ports. The receiver cannot stall: each word must
// be taken in the cycle it is shown.
// Reset clears the length table (every entry reads length zero) and the
// running count; entry bytes are undefined until written.
module byte_dictionary_expander_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     action_i,
  input  logic [7:0]                     entry_i,
  input  logic [7:0]                     position_i,
  input  logic [7:0]                     value_i,
  output logic                           strobe_o,
  output logic [31:0]                    out_bytes_o,
  output logic [2:0]                     byte_count_o,
  output logic                           last_o,
  output logic [31:0]                    total_length_o
);

  localparam logic [bde_pkg::CODE_W:0] CodeLimit = (bde_pkg::CODE_W+1)'(bde_pkg::NUM_CODES);

  logic                          accept;
  logic                          code_ok;
  logic                          len_wr;
  logic                          byte_wr;
  logic                          dec_start;
  logic [bde_pkg::LEN_W-1:0]     len_wdata;
  logic [bde_pkg::LEN_W-1:0]     len_rd;
  logic [bde_pkg::OUT_W-1:0]     rd_data;
  bde_pkg::mem_rd_t              rd;
  bde_pkg::emit_t                emit;
  logic [bde_pkg::TOTAL_W-1:0]   total;

  assign accept  = start && !busy;
  // codes beyond the dictionary are dropped by every action
  assign code_ok = {1'b0, entry_i} < CodeLimit;

  always_comb begin
    len_wr    = 1'b0;
    byte_wr   = 1'b0;
    dec_start = 1'b0;
    case (action_i)
      bde_pkg::ACT_SET_LEN:    len_wr    = accept && code_ok;
      bde_pkg::ACT_WRITE_BYTE: byte_wr   = accept && code_ok &&
          (position_i < bde_pkg::SLOT_W'(bde_pkg::MAX_ENTRY_LEN));
      bde_pkg::ACT_DECODE:     dec_start = accept && code_ok;
      default:                 len_wr    = 1'b0;   // unused action: no effect
    endcase
  end

  // lengths above the maximum clamp to it
  assign len_wdata = (value_i > bde_pkg::LEN_W'(bde_pkg::MAX_ENTRY_LEN))
                   ? bde_pkg::LEN_W'(bde_pkg::MAX_ENTRY_LEN) : value_i;

  bde_len_table u_len_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (len_wr),
    .wr_addr_i (entry_i),
    .wr_data_i (len_wdata),
    .rd_en_i   (dec_start),
    .rd_addr_i (entry_i),
    .len_o     (len_rd)
  );

  bde_byte_mem u_byte_mem (
    .clk_i     (clk_i),
    .wr_en_i   (byte_wr),
    .wr_code_i (entry_i),
    .wr_pos_i  (position_i),
    .wr_data_i (value_i),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  bde_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dec_start),
    .code_i  (entry_i),
    .len_i   (len_rd),
    .busy_o  (busy),
    .rd_o    (rd),
    .emit_o  (emit),
    .total_o (total)
  );

  // lanes past the byte count go out as zero
  always_comb begin
    for (int l = 0; l < bde_pkg::OUT_LANES; l++) begin
      if (bde_pkg::CNT_W'(l) < emit.cnt) begin
        out_bytes_o[l*bde_pkg::BYTE_W +: bde_pkg::BYTE_W] =
            rd_data[l*bde_pkg::BYTE_W +: bde_pkg::BYTE_W];
      end else begin
        out_bytes_o[l*bde_pkg::BYTE_W +: bde_pkg::BYTE_W] = '0;
      end
    end
  end

  assign strobe_o       = emit.vld;
  assign byte_count_o   = emit.cnt;
  assign last_o         = emit.last;
  assign total_length_o = total;

endmodule
